FILE: hdl/zrle_pkg.sv
// Package for the zero run-length encoder.
// Holds the payload structs and shared constants; no dependencies.
package zrle_pkg;

  localparam int unsigned SymW = 16;
  localparam int unsigned CntW = 16;

  localparam logic [SymW-1:0] ZeroRunMaxReset = '1;
  localparam logic [CntW-1:0] FillerSat       = '1;

  // Input transaction as held in the input register
  typedef struct packed {
    logic [SymW-1:0] symbol_in;
    logic            end_of_stream;
  } zrle_in_t;

  // Result transaction
  typedef struct packed {
    logic [CntW-1:0] filler_pairs;
    logic [SymW-1:0] symbol_out;
    logic [CntW-1:0] zero_count;
    logic            pair_valid;
    logic            stream_done;
  } zrle_out_t;

endpackage

FILE: hdl/zrle_in_if.sv
// Symbol channel interface of the zero run-length encoder.
// Depends on nothing; carries valid, ready and the symbol payload.
interface zrle_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] symbol_in;
  logic        end_of_stream;

  modport source (output valid, output symbol_in, output end_of_stream, input ready);
  modport sink   (input valid, input symbol_in, input end_of_stream, output ready);
endinterface

FILE: hdl/zrle_out_if.sv
// Result channel interface of the zero run-length encoder.
// Depends on nothing; carries valid, ready and the pair payload.
interface zrle_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filler_pairs;
  logic [15:0] symbol_out;
  logic [15:0] zero_count;
  logic        pair_valid;
  logic        stream_done;

  modport source (output valid, output filler_pairs, output symbol_out,
                  output zero_count, output pair_valid, output stream_done,
                  input ready);
  modport sink   (input valid, input filler_pairs, input symbol_out,
                  input zero_count, input pair_valid, input stream_done,
                  output ready);
endinterface

FILE: hdl/zero_run_length_encoder_core.sv
// Zero run-length encoder: symbols in, (fillers, symbol, zeros) pairs out.
// Each symbol passes the input register, then its result is held in the result register.
// Throughput: one symbol per cycle unless a result is due and the output is full;
// the run count update and max-run compare sit in the single stage between registers.
// Reset (rst_n low, synchronous) empties both stages, clears the run and
// filler counts and sets the maximum run to 65535.
module zero_run_length_encoder_core
  import zrle_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [SymW-1:0] cfg_wdata,
  zrle_in_if.sink         in_ch,
  zrle_out_if.source      out_ch
);

  logic      s1_valid, s1_take, res_load, out_free;
  zrle_in_t  s1_data;
  zrle_out_t res_data;

  zrle_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  zrle_run_logic u_run_logic (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .out_free  (out_free),
    .s1_take   (s1_take),
    .res_load  (res_load),
    .res_data  (res_data)
  );

  zrle_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (res_load),
    .res_data (res_data),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

FILE: hdl/zrle_in_stage.sv
// Input register stage of the zero run-length encoder.
// Depends on zrle_pkg and zrle_in_if.
module zrle_in_stage
  import zrle_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  zrle_in_if.sink      in_ch,
  input  logic         s1_take,
  output logic         s1_valid,
  output zrle_in_t     s1_data
);

  logic     s1_valid_r, s1_valid_nxt;
  zrle_in_t s1_data_r;
  logic     in_fire;

  // Accept when empty or when the held transaction moves on this cycle
  assign in_ch.ready  = !s1_valid_r || s1_take;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r.symbol_in     <= in_ch.symbol_in;
      s1_data_r.end_of_stream <= in_ch.end_of_stream;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

FILE: hdl/zrle_run_logic.sv
// Run counting and pair forming for the zero run-length encoder.
// Depends on zrle_pkg; holds the run state and the maximum-run register.
module zrle_run_logic
  import zrle_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [SymW-1:0] cfg_wdata,
  input  logic            s1_valid,
  input  zrle_in_t        s1_data,
  input  logic            out_free,
  output logic            s1_take,
  output logic            res_load,
  output zrle_out_t       res_data
);

  logic [SymW-1:0] zero_run_max_r;
  logic [CntW-1:0] run_cnt_r, run_cnt_nxt;
  logic [CntW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [CntW:0]   run_inc;
  logic            is_zero, over, has_result;

  // Hold the maximum-run register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_max_r <= ZeroRunMaxReset;
    end else if (cfg_we) begin
      zero_run_max_r <= cfg_wdata;
    end
  end

  assign is_zero    = (s1_data.symbol_in == '0);
  assign run_inc    = {1'b0, run_cnt_r} + {{CntW{1'b0}}, 1'b1};
  assign over       = run_inc > {1'b0, zero_run_max_r};
  assign has_result = !is_zero || s1_data.end_of_stream;

  // Advance unless a result is due and the output register is full
  assign s1_take  = s1_valid && (!has_result || out_free);
  assign res_load = s1_take && has_result;

  // Next state and result
  always_comb begin
    run_cnt_nxt  = '0;
    fill_cnt_nxt = '0;
    res_data     = '0;
    if (is_zero) begin
      if (!s1_data.end_of_stream) begin
        run_cnt_nxt  = over ? '0 : run_inc[CntW-1:0];
        fill_cnt_nxt = (over && fill_cnt_r != FillerSat) ? fill_cnt_r + 1'b1 : fill_cnt_r;
      end
      // Bare end marker: drop trailing fillers and zeros
      res_data.stream_done = 1'b1;
    end else begin
      res_data.filler_pairs = fill_cnt_r;
      res_data.symbol_out   = s1_data.symbol_in;
      res_data.zero_count   = run_cnt_r;
      res_data.pair_valid   = 1'b1;
      res_data.stream_done  = s1_data.end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r  <= '0;
      fill_cnt_r <= '0;
    end else if (s1_take) begin
      run_cnt_r  <= run_cnt_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

endmodule

FILE: hdl/zrle_out_stage.sv
// Result register stage of the zero run-length encoder.
// Depends on zrle_pkg and zrle_out_if.
module zrle_out_stage
  import zrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_load,
  input  zrle_out_t   res_data,
  output logic        out_free,
  zrle_out_if.source  out_ch
);

  logic      out_valid_r, out_valid_nxt;
  zrle_out_t out_data_r;

  // Free when empty or when the held transaction leaves this cycle
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = res_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_data;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.filler_pairs = out_data_r.filler_pairs;
  assign out_ch.symbol_out   = out_data_r.symbol_out;
  assign out_ch.zero_count   = out_data_r.zero_count;
  assign out_ch.pair_valid   = out_data_r.pair_valid;
  assign out_ch.stream_done  = out_data_r.stream_done;

endmodule

FILE: hdl/zrle_checker.sv
// Port-level checks for the zero run-length encoder.
// Depends on zero_run_length_encoder_core; attached by the bind below.
module zrle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] filler_pairs,
  input logic [15:0] symbol_out,
  input logic [15:0] zero_count,
  input logic        pair_valid,
  input logic        stream_done
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(symbol_out) && $stable(zero_count)
      && $stable(filler_pairs) && $stable(pair_valid) && $stable(stream_done))
    else $error("result payload changed while stalled");

  // A bare end marker closes the stream and carries nothing
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pair_valid |-> stream_done && filler_pairs == '0
      && symbol_out == '0 && zero_count == '0)
    else $error("bare end marker malformed");

  // A pair always carries a nonzero symbol
  a_pair_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pair_valid |-> symbol_out != '0)
    else $error("pair with zero symbol");

endmodule

bind zero_run_length_encoder_core zrle_checker u_zrle_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .filler_pairs (out_ch.filler_pairs),
  .symbol_out   (out_ch.symbol_out),
  .zero_count   (out_ch.zero_count),
  .pair_valid   (out_ch.pair_valid),
  .stream_done  (out_ch.stream_done)
);

FILE: sim/zrle_pair_checker.sv
// Scoreboard for the zero run-length encoder: predicts result pairs from accepted symbols.
// Depends on zrle_pkg and the zrle_in_if / zrle_out_if channel interfaces.
module zrle_pair_checker
  import zrle_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [SymW-1:0] cfg_wdata,
  zrle_in_if              in_ch,
  zrle_out_if             out_ch,
  output int              fail_count,
  output int              pending,
  output int              results_checked
);

  localparam int MaxReports = 30;

  // Predictor state: zeros since the last pair or filler, fillers not yet reported
  logic [16:0]     run_len;
  logic [CntW-1:0] fillers_held;
  logic [SymW-1:0] max_run;
  zrle_out_t       pair_q[$];
  int              errs = 0;
  int              n_ok = 0;

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      if (errs < MaxReports)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : monitor
    zrle_out_t want;
    if (!rst_n) begin
      max_run      = ZeroRunMaxReset;
      run_len      = '0;
      fillers_held = '0;
      pair_q.delete();
    end else begin
      // Compare each result transaction with the oldest predicted pair
      if (out_ch.valid && out_ch.ready) begin
        n_ok++;
        if (pair_q.size() == 0) begin
          if (errs < MaxReports)
            $display("%0t: unexpected result: expected none, actual %h/%h/%h/%b/%b",
                     $time, out_ch.filler_pairs, out_ch.symbol_out, out_ch.zero_count,
                     out_ch.pair_valid, out_ch.stream_done);
          errs++;
        end else begin
          want = pair_q.pop_front();
          check_field("filler_pairs", want.filler_pairs, out_ch.filler_pairs);
          check_field("symbol_out", want.symbol_out, out_ch.symbol_out);
          check_field("zero_count", want.zero_count, out_ch.zero_count);
          check_field("pair_valid", 16'(want.pair_valid), 16'(out_ch.pair_valid));
          check_field("stream_done", 16'(want.stream_done), 16'(out_ch.stream_done));
        end
      end

      // Predict the pair or end marker, if any, caused by each accepted symbol transaction
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.symbol_in == '0) begin
          run_len = run_len + 17'd1;
          // Cut the run into a filler pair once it passes the maximum
          if (run_len > {1'b0, max_run}) begin
            if (fillers_held != FillerSat)
              fillers_held = fillers_held + 1'b1;
            run_len = '0;
          end
          // Drop trailing zeros and fillers; emit a bare end marker
          if (in_ch.end_of_stream) begin
            want             = '0;
            want.stream_done = 1'b1;
            pair_q.insert(pair_q.size(), want);
            run_len      = '0;
            fillers_held = '0;
          end
        end else begin
          want.filler_pairs = fillers_held;
          want.symbol_out   = in_ch.symbol_in;
          want.zero_count   = run_len[15:0];
          want.pair_valid   = 1'b1;
          want.stream_done  = in_ch.end_of_stream;
          pair_q.insert(pair_q.size(), want);
          run_len      = '0;
          fillers_held = '0;
        end
      end

      // Apply a register write after this edge's symbol
      if (cfg_we)
        max_run = cfg_wdata;
    end
    pending         <= pair_q.size();
    fail_count      <= errs;
    results_checked <= n_ok;
  end

endmodule

FILE: sim/zero_run_length_encoder_core_tb.sv
// Top of the zero run-length encoder test: clock, reset, symbol stimulus and verdict.
// Depends on zrle_pkg, the channel interfaces, the core and zrle_pair_checker.
module zero_run_length_encoder_core_tb;
  import zrle_pkg::*;

  localparam int DrainCycles = 6;
  localparam int StallLimit  = 2000;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [SymW-1:0] cfg_wdata;

  zrle_in_if  in_ch();
  zrle_out_if out_ch();

  int fail_count;
  int pending;
  int results_checked;
  int quiet_cycles = 0;
  int n_sent       = 0;
  int n_streams    = 0;
  int n_settings   = 0;
  bit src_idle_en  = 1'b0;
  bit snk_idle_en  = 1'b0;

  zero_run_length_encoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  zrle_pair_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Zero run length, scaled to small maxima (up to 50) so runs get split
  function automatic int pick_run(input int unsigned mx);
    int unsigned span;
    span = (mx <= 50) ? 3 * mx + 4 : 30;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      9:          return $urandom_range(0, 2 * span);
      default:    return $urandom_range(1, span);
    endcase
  endfunction

  function automatic logic [15:0] pick_nonzero();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'h0001;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Present one symbol and hold it until the transaction completes
  task automatic send_symbol(input logic [15:0] sym, input logic eos);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.symbol_in     <= sym;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    if (eos) n_streams++;
  endtask

  task automatic send_zeros(input int n);
    for (int i = 0; i < n; i++) send_symbol('0, 1'b0);
  endtask

  // Hold the sender until every predicted pair is out, then idle as asked by extra
  task automatic wait_idle(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_max_run(input logic [15:0] v);
    wait_idle(DrainCycles);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  // One stream of random runs and nonzero symbols, with rare stray end marks
  task automatic random_stream(input int unsigned mx);
    int n_sym;
    int run;
    bit closed;
    n_sym  = $urandom_range(1, 10);
    closed = 1'b0;
    for (int k = 0; k < n_sym; k++) begin
      run = pick_run(mx);
      for (int z = 0; z < run; z++) send_symbol('0, $urandom_range(0, 39) == 0);
      closed = (k == n_sym - 1) && ($urandom_range(0, 2) != 0);
      send_symbol(pick_nonzero(), closed);
    end
    if (!closed) begin
      send_zeros(pick_run(mx));
      send_symbol('0, 1'b1);
    end
  endtask

  // Result side: ready stretches broken by random stalls
  initial begin : sink_ready
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      n = snk_idle_en ? pick_gap() : 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("** zero_run_length_encoder_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned mx;
    int phase_start;
    int pause_at;
    bit paused;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.symbol_in     = '0;
    in_ch.end_of_stream = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset maximum: plain pairs, lone zero stream, short runs, end markers
    send_symbol(16'hFFFF, 1'b0);
    send_symbol(16'h0001, 1'b1);
    send_symbol('0, 1'b1);
    send_zeros(3);
    send_symbol(16'h8000, 1'b0);
    send_zeros(2);
    send_symbol('0, 1'b1);
    send_symbol(16'h5555, 1'b0);
    send_symbol(16'hAAAA, 1'b1);

    // Zero maximum: every zero becomes a filler
    set_max_run('0);
    send_zeros(2);
    send_symbol(16'h1234, 1'b0);
    send_symbol('0, 1'b1);

    // Small maximum: runs cut exactly at and past the limit
    set_max_run(16'd3);
    send_zeros(4);
    send_symbol(16'h7FFF, 1'b0);
    send_zeros(7);
    send_symbol(16'hAAAA, 1'b1);
    send_zeros(8);
    send_symbol(16'h0002, 1'b0);
    send_zeros(3);
    send_symbol('0, 1'b1);

    // Full maximum: longer runs counted in one pair
    set_max_run(16'hFFFF);
    send_zeros(40);
    send_symbol(16'h00FF, 1'b0);
    send_zeros(25);
    send_symbol(16'hFF00, 1'b1);

    // Random streams under several maxima and idle patterns
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       mx = 0;
        1:       mx = 1;
        2:       mx = 2;
        3:       mx = 7;
        4:       mx = $urandom_range(20, 60);
        5:       mx = 16'hFFFF;
        default: mx = $urandom_range(0, 65535);
      endcase
      set_max_run(16'(mx));
      src_idle_en = (p != 0) && (p != 4);
      snk_idle_en = (p != 0) && (p != 3);
      phase_start = n_sent;
      pause_at    = $urandom_range(10, 50);
      paused      = 1'b0;
      while (n_sent - phase_start < 70) begin
        random_stream(mx);
        // Let the result side empty out once per phase
        if (!paused && n_sent - phase_start >= pause_at) begin
          wait_idle(0);
          paused = 1'b1;
        end
      end
    end

    wait_idle(DrainCycles);
    $display("Sent %0d symbols in %0d streams under %0d maximum-run settings;",
             n_sent, n_streams, n_settings);
    $display("checked %0d result pairs and end markers.", results_checked);
    if (fail_count == 0 && pending == 0)
      $display("** zero_run_length_encoder_core: PASSED **");
    else
      $display("** zero_run_length_encoder_core: FAILED **");
    $finish;
  end

endmodule
